[sv/tape_edge_to_pcm_runs_top_defines.svh]
// Assertion macros shared by the tape edge to PCM run converter
`ifndef TAPE_EDGE_TO_PCM_RUNS_TOP_DEFINES_SVH
`define TAPE_EDGE_TO_PCM_RUNS_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset
`define TEPR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define TEPR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[sv/tepr_pkg.sv]
// Package: widths, reset values and shared types of the tape edge to PCM run converter
`timescale 1ns / 1ps

package tepr_pkg;

  localparam int ACC_BITS_DEF = 40;
  localparam int TICKS_W      = 32;
  localparam int TPS_W        = 22;
  localparam int TERM_W       = 12;
  localparam int RUN_W        = 40;
  localparam int CFG_W        = TPS_W;

  localparam logic [RUN_W-1:0]  RUN_MAX    = {RUN_W{1'b1}};
  localparam logic [TPS_W-1:0]  TPS_RESET  = 22'd79;
  localparam logic [TERM_W-1:0] TERM_RESET = 12'd45;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_TPS  = 1'b0,
    CFG_TERM = 1'b1
  } cfg_idx_t;

  // Divider status seen by the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

[sv/tape_edge_to_pcm_runs_top.sv]
// Top level: tape edge to PCM run converter with sequencer and output register
//
//  channel | signals                                  | moves
//  --------+------------------------------------------+------------------------------
//  s_      | tvalid tready tdata tuser tlast          | one tape edge request
//  m_      | tvalid tready tdata tuser tlast          | one (level, length) run
//  cfg_    | we index data                            | register write, no handshake
//
// A real edge runs ACC_BITS divider steps (40 at the default width), then the sequencer sees
// the divider finish, then plans and loads; an edge with no level change skips the divider.
// Extra results follow in turn. s_tready is high only while the sequencer is idle.
// rst is synchronous: state clears and registers return to 79 and 45.
// A low m_tready holds the output register and holds off the next edge's results.
`timescale 1ns / 1ps
`include "tape_edge_to_pcm_runs_top_defines.svh"

module tape_edge_to_pcm_runs_top #(
  parameter int ACC_BITS = tepr_pkg::ACC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [tepr_pkg::TICKS_W-1:0] s_tdata,   // [31:0] edge_ticks
  input  logic [2:0]                   s_tuser,   // [0] no_edge [1] force_low [2] force_high
  input  logic                         s_tlast,   // tape_end
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [tepr_pkg::RUN_W-1:0]   m_tdata,   // [39:0] run_length
  output logic [0:0]                   m_tuser,   // [0] sample_high
  output logic                         m_tlast,   // last_of_run
  input  logic                         cfg_we,
  input  logic [0:0]                   cfg_index,
  input  logic [tepr_pkg::CFG_W-1:0]   cfg_data
);

  localparam int WIDE = (ACC_BITS + 1 > tepr_pkg::RUN_W) ? ACC_BITS + 1 : tepr_pkg::RUN_W;

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_PLAN, S_EMIT} state_t;

  state_t state;

  logic [tepr_pkg::TPS_W-1:0]  tps;
  logic [tepr_pkg::TERM_W-1:0] term_len;

  logic                level;
  logic [ACC_BITS-1:0] balance;
  logic                emitted;
  logic                last_high;

  logic no_edge_q;
  logic tend_q;
  logic zero_q;

  logic [tepr_pkg::RUN_W-1:0] run_len;
  logic                       run_lvl;
  logic                       term_lvl;
  logic [2:0]                 pend;

  logic                       accept;
  logic [ACC_BITS:0]          sum_wide;
  logic [ACC_BITS-1:0]        sum_sat;
  logic                       level_next;
  logic [tepr_pkg::TPS_W-1:0] scale;

  logic [ACC_BITS-1:0]        quot;
  logic [tepr_pkg::TPS_W-1:0] rem;
  tepr_pkg::div_stat_t        div_stat;

  logic                       round_up;
  logic [WIDE-1:0]            len_wide;
  logic [tepr_pkg::RUN_W-1:0] len_sat;
  logic                       has_run;
  logic                       emitted_next;
  logic                       last_high_next;
  logic                       term_next;
  logic                       term_due;
  logic [2:0]                 pend_next;

  logic                       load;
  logic [2:0]                 pick;
  logic [2:0]                 rest;

  assign accept   = s_tvalid && s_tready;
  assign s_tready = (state == S_IDLE);
  assign scale    = (tps == '0) ? tepr_pkg::TPS_W'(1) : tps;

  // Saturating add of the edge into the accumulator
  assign sum_wide = {1'b0, balance} + (ACC_BITS + 1)'(s_tdata);
  assign sum_sat  = sum_wide[ACC_BITS] ? {ACC_BITS{1'b1}} : sum_wide[ACC_BITS-1:0];

  // Level change: no_edge holds the level, force low wins over force high, else toggle
  always_comb begin
    if (s_tuser[0]) level_next = level;
    else if (s_tuser[1]) level_next = 1'b0;
    else if (s_tuser[2]) level_next = 1'b1;
    else level_next = ~level;
  end

  tepr_div #(.ACC_BITS(ACC_BITS)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (accept && !s_tuser[0]),
    .dividend (sum_sat),
    .divisor  (scale),
    .quot     (quot),
    .rem      (rem),
    .stat     (div_stat)
  );

  // Round the quotient and plan the results of this edge
  always_comb begin
    round_up       = rem > (scale >> 1);
    len_wide       = WIDE'(quot) + WIDE'(round_up);
    len_sat        = (len_wide > WIDE'(tepr_pkg::RUN_MAX)) ? tepr_pkg::RUN_MAX
                                                           : len_wide[tepr_pkg::RUN_W-1:0];
    has_run        = !no_edge_q && (len_wide != '0);
    emitted_next   = emitted || has_run;
    last_high_next = has_run ? level : last_high;
    term_next      = ~last_high_next;
    term_due       = tend_q && zero_q && emitted_next;
    pend_next      = {term_due && term_next, term_due && (term_len != '0), has_run};
  end

  // Pick the pending result in fixed order: run, then terminator run, then the low tail
  always_comb begin
    if (pend[0]) pick = 3'b001;
    else if (pend[1]) pick = 3'b010;
    else if (pend[2]) pick = 3'b100;
    else pick = 3'b000;
    rest = pend & ~pick;
  end

  assign load = (state == S_EMIT) && (!m_tvalid || m_tready) && (pend != '0);

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tps      <= tepr_pkg::TPS_RESET;
      term_len <= tepr_pkg::TERM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tepr_pkg::CFG_TPS:  tps      <= cfg_data[tepr_pkg::TPS_W-1:0];
        tepr_pkg::CFG_TERM: term_len <= cfg_data[tepr_pkg::TERM_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer, tape state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      level     <= 1'b0;
      balance   <= '0;
      emitted   <= 1'b0;
      last_high <= 1'b0;
      pend      <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            level     <= level_next;
            balance   <= sum_sat;
            no_edge_q <= s_tuser[0];
            tend_q    <= s_tlast;
            zero_q    <= (s_tdata == '0);
            state     <= s_tuser[0] ? S_PLAN : S_DIV;
          end
        end
        S_DIV: begin
          if (div_stat.done) state <= S_PLAN;
        end
        S_PLAN: begin
          run_len   <= len_sat;
          run_lvl   <= level;
          term_lvl  <= term_next;
          pend      <= pend_next;
          emitted   <= emitted_next;
          last_high <= last_high_next;
          if (!no_edge_q) balance <= round_up ? '0 : ACC_BITS'(rem);
          // End of tape: drop all tape state
          if (tend_q) begin
            level     <= 1'b0;
            balance   <= '0;
            emitted   <= 1'b0;
            last_high <= 1'b0;
          end
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (pend == '0) begin
            state <= S_IDLE;
          end else if (load) begin
            m_tvalid <= 1'b1;
            m_tlast  <= (rest == '0);
            pend     <= rest;
            if (pick[0]) begin
              m_tuser <= run_lvl;
              m_tdata <= run_len;
            end else if (pick[1]) begin
              m_tuser <= term_lvl;
              m_tdata <= tepr_pkg::RUN_W'(term_len);
            end else begin
              m_tuser <= 1'b0;
              m_tdata <= tepr_pkg::RUN_W'(1);
            end
            if (rest == '0) state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Checks on the sequencer and the divider
  `TEPR_ASSERT_IMP(a_ready_div_idle, s_tready, !div_stat.busy, "edge request taken while dividing")
  `TEPR_ASSERT_IMP(a_run_nonzero, m_tvalid, m_tdata != '0, "empty run on the output")
  `TEPR_ASSERT_NXT(a_div_start, s_tvalid && s_tready && !s_tuser[0], div_stat.busy, "divider not started")

endmodule

[sv/tepr_div.sv]
// Bit-serial restoring divider: one quotient bit per cycle
`timescale 1ns / 1ps

module tepr_div #(
  parameter int ACC_BITS = tepr_pkg::ACC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [ACC_BITS-1:0]        dividend,
  input  logic [tepr_pkg::TPS_W-1:0] divisor,
  output logic [ACC_BITS-1:0]        quot,
  output logic [tepr_pkg::TPS_W-1:0] rem,
  output tepr_pkg::div_stat_t        stat
);

  localparam int CNT_W = $clog2(ACC_BITS);

  logic [CNT_W-1:0]            cnt;
  logic                        busy;
  logic                        done;
  logic [tepr_pkg::TPS_W:0]    shifted;
  logic [tepr_pkg::TPS_W:0]    diff;
  logic                        ge;

  // Shared subtract and compare of the partial remainder
  assign shifted = {rem, quot[ACC_BITS-1]};
  assign ge      = shifted >= {1'b0, divisor};
  assign diff    = shifted - {1'b0, divisor};

  assign stat.busy = busy;
  assign stat.done = done;

  // Step the partial remainder, shift quotient bits in behind the dividend
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quot <= dividend;
        rem  <= '0;
        cnt  <= CNT_W'(ACC_BITS - 1);
        busy <= 1'b1;
      end else if (busy) begin
        rem  <= ge ? diff[tepr_pkg::TPS_W-1:0] : shifted[tepr_pkg::TPS_W-1:0];
        quot <= {quot[ACC_BITS-2:0], ge};
        cnt  <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
